// ===== hdl/pbps_pkg.sv =====
// pbps_pkg: shared types and constants for the power button press sequencer.
// Used by pbps_regs, pbps_core and power_button_press_sequencer.
`default_nettype none

package pbps_pkg;

  localparam int LED_COUNT = 4;
  localparam int CNT_W = $clog2(LED_COUNT + 1);
  localparam int LED_SHOWN = (LED_COUNT > 4) ? 4 : LED_COUNT;
  localparam logic [3:0] ALL_LEDS = 4'((1 << LED_SHOWN) - 1);

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [15:0] WINDOW_RESET = 16'd1000;
  localparam logic [13:0] INTERVAL_RESET = 14'd500;
  localparam logic [15:0] HOLD_RESET = 16'd2000;
  localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

  // register indexes, word addressed
  localparam logic [1:0] REG_WINDOW = 2'd0;
  localparam logic [1:0] REG_INTERVAL = 2'd1;
  localparam logic [1:0] REG_HOLD = 2'd2;

  typedef struct packed {
    logic [15:0] window;
    logic [13:0] interval;
    logic [15:0] hold;
  } cfg_t;

  typedef struct packed {
    logic [3:0] led_mask;
    logic       power_led;
    logic       start_homing;
    logic [2:0] phase;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/pbps_regs.sv =====
// pbps_regs: APB-style configuration registers (window, LED interval, hold).
// Depends on pbps_pkg.
`default_nettype none

module pbps_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [pbps_pkg::PADDR_W-1:0] paddr,
  input  wire logic [pbps_pkg::PDATA_W-1:0] pwdata,
  output logic      [pbps_pkg::PDATA_W-1:0] prdata,
  output logic                            pready,
  output pbps_pkg::cfg_t                  cfg_o
);
  import pbps_pkg::*;

  cfg_t       cfg_q;
  logic [1:0] idx;
  logic       wr_en;

  assign idx = paddr[3:2];
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window <= WINDOW_RESET;
      cfg_q.interval <= INTERVAL_RESET;
      cfg_q.hold <= HOLD_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_WINDOW:   cfg_q.window <= pwdata[15:0];
        REG_INTERVAL: cfg_q.interval <= pwdata[13:0];
        REG_HOLD:     cfg_q.hold <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_WINDOW:   prdata = {16'd0, cfg_q.window};
      REG_INTERVAL: prdata = {18'd0, cfg_q.interval};
      REG_HOLD:     prdata = {16'd0, cfg_q.hold};
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/pbps_core.sv =====
// pbps_core: gesture state machine with hold timer and LED step threshold.
// Depends on pbps_pkg; updates its state once per step_en.
`default_nettype none

module pbps_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_en_i,
  input  wire logic           pressed_i,
  input  pbps_pkg::cfg_t      cfg_i,
  output pbps_pkg::res_t      res_o
);
  import pbps_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_WAIT_REL    = 3'd1,
    PH_WAIT_SECOND = 3'd2,
    PH_HOLD        = 3'd3,
    PH_DONE        = 3'd4
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [15:0]      elapsed_q, elapsed_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [16:0]      thr_q, thr_d;
  logic [3:0]       led_q, led_d;
  logic             pwr_q, pwr_d;
  logic             homing;
  logic [15:0]      elapsed_inc;

  assign elapsed_inc = (elapsed_q < ELAPSED_MAX) ? elapsed_q + 16'd1 : elapsed_q;

  always_comb begin
    phase_d = phase_q;
    elapsed_d = elapsed_q;
    cnt_d = cnt_q;
    thr_d = thr_q;
    led_d = led_q;
    pwr_d = pwr_q;
    homing = 1'b0;
    case (phase_q)
      PH_WAIT_REL: begin
        if (!pressed_i) begin
          phase_d = PH_WAIT_SECOND;
          elapsed_d = '0;
        end
      end
      PH_WAIT_SECOND: begin
        // window expiry wins over a press on the same tick
        if (elapsed_q >= cfg_i.window) begin
          phase_d = PH_IDLE;
          cnt_d = '0;
          led_d = '0;
        end else if (pressed_i) begin
          phase_d = PH_HOLD;
          elapsed_d = '0;
          cnt_d = '0;
          thr_d = {3'd0, cfg_i.interval};
        end else begin
          elapsed_d = elapsed_inc;
        end
      end
      PH_HOLD: begin
        if (!pressed_i) begin
          phase_d = PH_IDLE;
          cnt_d = '0;
          led_d = '0;
        end else begin
          elapsed_d = elapsed_inc;
          if (cnt_q < CNT_W'(LED_COUNT) && {1'b0, elapsed_inc} >= thr_q) begin
            // shifts past the visible LEDs leave the mask alone
            led_d = led_q & ~(4'b0001 << cnt_q);
            cnt_d = cnt_q + CNT_W'(1);
            thr_d = thr_q + {3'd0, cfg_i.interval};
          end
          if (elapsed_inc >= cfg_i.hold) begin
            phase_d = PH_DONE;
            pwr_d = 1'b1;
          end
        end
      end
      PH_DONE: begin
        if (!pressed_i) begin
          phase_d = PH_IDLE;
          homing = 1'b1;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        if (pressed_i) begin
          phase_d = PH_WAIT_REL;
          led_d = ALL_LEDS;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      elapsed_q <= '0;
      cnt_q <= '0;
      thr_q <= '0;
      led_q <= '0;
      pwr_q <= 1'b0;
    end else if (step_en_i) begin
      phase_q <= phase_d;
      elapsed_q <= elapsed_d;
      cnt_q <= cnt_d;
      thr_q <= thr_d;
      led_q <= led_d;
      pwr_q <= pwr_d;
    end
  end

  assign res_o.led_mask = led_d;
  assign res_o.power_led = pwr_d;
  assign res_o.start_homing = homing;
  assign res_o.phase = phase_d;

endmodule

`default_nettype wire

// ===== hdl/power_button_press_sequencer.sv =====
// power_button_press_sequencer: top level with input register, result register
// and handshake. Depends on pbps_pkg, pbps_regs and pbps_core.
`default_nettype none

// Takes one tick item per clock cycle unless stalled by the sink, and returns
// exactly one result per item, showing LED mask, power LED, homing pulse and
// phase after that tick. An item waits in the input register until it advances,
// and its result is then registered in the result register, raising
// out_valid_o. A new item is taken while a finished result waits for the sink.
// Registers may be written only while no item is in flight.
module power_button_press_sequencer (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         button_pressed_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [3:0]                        led_mask_o,
  output logic                              power_led_o,
  output logic                              start_homing_o,
  output logic [2:0]                        sequence_phase_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [pbps_pkg::PADDR_W-1:0] paddr,
  input  wire logic [pbps_pkg::PDATA_W-1:0] pwdata,
  output logic      [pbps_pkg::PDATA_W-1:0] prdata,
  output logic                              pready
);
  import pbps_pkg::*;

  cfg_t cfg;
  res_t res_next;
  res_t res_q;
  logic s1_valid_q;
  logic s1_pressed_q;
  logic out_valid_q;
  logic adv;
  logic in_acc;

  assign adv = s1_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && !adv;
  assign in_acc = in_valid_i && !in_stall_o;

  pbps_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pbps_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (adv),
    .pressed_i (s1_pressed_q),
    .cfg_i     (cfg),
    .res_o     (res_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pressed_q <= button_pressed_i;
    end
    if (adv) begin
      res_q <= res_next;
    end
  end

  assign out_valid_o = out_valid_q;
  assign led_mask_o = res_q.led_mask;
  assign power_led_o = res_q.power_led;
  assign start_homing_o = res_q.start_homing;
  assign sequence_phase_o = res_q.phase;

  // homing only follows a completed hold
  a_homing_needs_power: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && start_homing_o |-> power_led_o)
    else $error("start_homing without power led");

  a_adv_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_o)
    else $error("advanced item did not reach result register");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_o && out_stall_i)
    else $error("input stalled with room downstream");

endmodule

`default_nettype wire
